[rtl/rau_pkg.sv]
// rau_pkg: types, constants and codes shared by the rational arithmetic unit
// no dependencies
`timescale 1ns / 1ps
package rau_pkg;

  localparam int unsigned Width = 32;
  localparam int unsigned MagW  = 2 * Width + 1;  // magnitude of a cross-product sum

  typedef enum logic [1:0] {
    ActAdd = 2'd0,
    ActMul = 2'd1,
    ActDiv = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StZeroDen = 2'd1,
    StOvf     = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    SIdle, SMul0, SMul1, SMul2, SSum, SGcdInit, SGcdDiv, SGcdStep,
    SRedNum, SRedDen, SCheck, SOut
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } in_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [30:0] res_den;
    logic [1:0]  status;
  } out_t;

endpackage

[rtl/rau_div.sv]
// rau_div: restoring divider, one quotient bit per cycle, quotient and remainder
// depends on rau_pkg
`timescale 1ns / 1ps
module rau_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rau_pkg::MagW-1:0]    dividend_i,
  input  logic [rau_pkg::MagW-1:0]    divisor_i,
  output logic                        done_o,
  output logic [rau_pkg::MagW-1:0]    quot_o,
  output logic [rau_pkg::MagW-1:0]    rem_o
);
  import rau_pkg::*;

  localparam int unsigned CntW = $clog2(MagW + 1);

  logic [MagW-1:0] quot_q, quot_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [MagW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(MagW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quot_q[MagW-1]} - {1'b0, dvs_q};
      if (!trial[MagW]) begin
        rem_d  = trial[MagW-1:0];
        quot_d = {quot_q[MagW-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[MagW-2:0], quot_q[MagW-1]};
        quot_d = {quot_q[MagW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule

[rtl/rational_arith_unit_top.sv]
// rational_arith_unit_top: sequencer around one shared multiplier and one divider
// depends on rau_pkg and rau_div
`timescale 1ns / 1ps
// Adds, multiplies or divides two fractions exactly and returns the result
// reduced by the Euclidean gcd, with a positive denominator and the sign on
// the numerator; zero comes out as 0/1. One item is in flight at a time and
// in_ready_o is low until its result beat is taken. Every Euclid step and
// each of the two reducing divisions runs the bit-serial divider, so the time
// per item grows with the number of Euclid steps; zero-denominator errors and
// zero results skip the divider, and too-wide results return an overflow status.
module rational_arith_unit_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rau_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rau_pkg::out_t  out_data_o
);
  import rau_pkg::*;

  state_e          state_q, state_d;
  logic [1:0]      act_q, act_d;
  logic [Width-1:0] an_q, ad_q, bn_q, bd_q, an_d, ad_d, bn_d, bd_d;   // magnitudes
  logic            ans_q, ads_q, bns_q, bds_q, ans_d, ads_d, bns_d, bds_d;
  logic [MagW-1:0] p0_q, p0_d, x_q, x_d, y_q, y_d, num_q, num_d, den_q, den_d;
  logic            p0s_q, p0s_d, nneg_q, nneg_d;
  out_t            out_q, out_d;

  // shared multiplier
  logic [Width-1:0]   mul_a, mul_b;
  logic [2*Width-1:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // shared divider
  logic            div_start, div_done;
  logic [MagW-1:0] div_n, div_d, div_q, div_r;
  rau_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_n), .divisor_i(div_d),
    .done_o(div_done), .quot_o(div_q), .rem_o(div_r)
  );

  function automatic logic [Width-1:0] mag_of(logic [31:0] f);
    return f[Width-1] ? (Width)'(-f[Width-1:0]) : f[Width-1:0];
  endfunction

  logic            zero_err;
  logic            sgn_a, sgn_b;
  logic [MagW:0]   sum_diff;
  logic [MagW-1:0] limit;

  always_comb begin
    state_d = state_q;
    act_d = act_q;
    an_d = an_q; ad_d = ad_q; bn_d = bn_q; bd_d = bd_q;
    ans_d = ans_q; ads_d = ads_q; bns_d = bns_q; bds_d = bds_q;
    p0_d = p0_q; p0s_d = p0s_q; x_d = x_q; y_d = y_q;
    num_d = num_q; den_d = den_q; nneg_d = nneg_q;
    out_d = out_q;
    mul_a = '0; mul_b = '0;
    div_start = 1'b0; div_n = x_q; div_d = y_q;
    zero_err = 1'b0; sgn_a = 1'b0; sgn_b = 1'b0; sum_diff = '0;
    limit = MagW'(1) << (Width - 1);
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          // the spare action code behaves as add
          act_d = ((in_data_i.action == ActMul) || (in_data_i.action == ActDiv))
                ? in_data_i.action : ActAdd;
          an_d = mag_of(in_data_i.a_num); ans_d = in_data_i.a_num[Width-1];
          ad_d = mag_of(in_data_i.a_den); ads_d = in_data_i.a_den[Width-1];
          bn_d = mag_of(in_data_i.b_num); bns_d = in_data_i.b_num[Width-1];
          bd_d = mag_of(in_data_i.b_den); bds_d = in_data_i.b_den[Width-1];
          zero_err = (in_data_i.a_den[Width-1:0] == '0)
                  || (in_data_i.b_den[Width-1:0] == '0)
                  || ((in_data_i.action == ActDiv) && (in_data_i.b_num[Width-1:0] == '0));
          if (zero_err) begin
            out_d = '{res_num: '0, res_den: '0, status: StZeroDen};
            state_d = SOut;
          end else begin
            state_d = SMul0;
          end
        end
      end
      // first product: an*bd (add, div) or an*bn (mul)
      SMul0: begin
        mul_a = an_q;
        mul_b = (act_q == ActMul) ? bn_q : bd_q;
        p0_d = MagW'(mul_p);
        p0s_d = ans_q ^ ((act_q == ActMul) ? bns_q : bds_q);
        state_d = SMul1;
      end
      // denominator: ad*bd, or ad*bn for divide
      SMul1: begin
        mul_a = ad_q;
        mul_b = (act_q == ActDiv) ? bn_q : bd_q;
        den_d = MagW'(mul_p);
        nneg_d = ads_q ^ ((act_q == ActDiv) ? bns_q : bds_q);  // den sign for now
        if (act_q == ActAdd) begin
          state_d = SMul2;
        end else begin
          num_d = p0_q;
          p0s_d = p0s_q;
          state_d = SSum;
        end
      end
      SMul2: begin
        mul_a = bn_q;
        mul_b = ad_q;
        x_d = MagW'(mul_p);   // second cross product
        state_d = SSum;
      end
      SSum: begin
        if (act_q == ActAdd) begin
          sgn_a = p0s_q && (p0_q != '0);
          sgn_b = (bns_q ^ ads_q) && (x_q != '0);
          if (sgn_a == sgn_b) begin
            num_d = p0_q + x_q; p0s_d = sgn_a;
          end else begin
            sum_diff = {1'b0, p0_q} - {1'b0, x_q};
            if (!sum_diff[MagW]) begin
              num_d = sum_diff[MagW-1:0]; p0s_d = sgn_a;
            end else begin
              num_d = x_q - p0_q; p0s_d = sgn_b;
            end
          end
        end
        state_d = SGcdInit;
      end
      SGcdInit: begin
        nneg_d = p0s_q ^ nneg_q;
        if (num_q == '0) begin
          out_d = '{res_num: '0, res_den: 31'd1, status: StOk};
          state_d = SOut;
        end else begin
          x_d = num_q;
          y_d = den_q;
          state_d = SGcdStep;
        end
      end
      SGcdStep: begin
        if (y_q == '0) begin
          div_n = num_q; div_d = x_q; div_start = 1'b1;   // x holds the gcd
          state_d = SRedNum;
        end else begin
          div_start = 1'b1;
          state_d = SGcdDiv;
        end
      end
      SGcdDiv: begin
        if (div_done) begin
          x_d = y_q;
          y_d = div_r;
          state_d = SGcdStep;
        end
      end
      SRedNum: begin
        if (div_done) begin
          num_d = div_q;
          div_n = den_q; div_d = x_q; div_start = 1'b1;
          state_d = SRedDen;
        end
      end
      SRedDen: begin
        if (div_done) begin
          den_d = div_q;
          state_d = SCheck;
        end
      end
      SCheck: begin
        if ((den_q > limit - 1'b1) || (num_q > (nneg_q ? limit : limit - 1'b1))) begin
          out_d = '{res_num: '0, res_den: '0, status: StOvf};
        end else begin
          out_d.res_num = nneg_q ? 32'(-num_q) : 32'(num_q);
          out_d.res_den = 31'(den_q);
          out_d.status  = StOk;
        end
        state_d = SOut;
      end
      SOut: begin
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    an_q <= an_d; ad_q <= ad_d; bn_q <= bn_d; bd_q <= bd_d;
    ans_q <= ans_d; ads_q <= ads_d; bns_q <= bns_d; bds_q <= bds_d;
    p0_q <= p0_d; p0s_q <= p0s_d; x_q <= x_d; y_q <= y_d;
    num_q <= num_d; den_q <= den_d; nneg_q <= nneg_d;
    out_q <= out_d;
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign out_data_o  = out_q;
endmodule

[rtl/rau_checker.sv]
// rau_checker: port-level assertions for the rational arithmetic unit
// depends on rau_pkg, bound into rational_arith_unit_top
`timescale 1ns / 1ps
module rau_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input rau_pkg::out_t out_data_o
);
  import rau_pkg::*;

  // one item at a time: no input beat while a result waits
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != StOk) |->
      (out_data_o.res_num == '0) && (out_data_o.res_den == '0))
    else $error("error result not cleared");

  a_ok_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StOk) |-> out_data_o.res_den != '0)
    else $error("zero denominator on ok result");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after accept");
endmodule

bind rational_arith_unit_top rau_checker u_rau_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);

[bench/testbench.sv]
// testbench: self-checking bench for rational_arith_unit_top
// depends on rau_pkg and the rtl of the rational arithmetic unit
`timescale 1ns / 1ps
module testbench;
  import rau_pkg::*;

  localparam logic [1:0] ActSpare = 2'd3;  // unused code, behaves as add
  localparam int unsigned CycleLimit = 30_000_000;
  localparam logic [31:0] MinInt = 32'h8000_0000;
  localparam logic [31:0] MaxInt = 32'h7fff_ffff;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  out_t  out_data;

  out_t        pending_results[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned hold_cycles = 0;
  bit          no_idle = 1'b0;

  rational_arith_unit_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // magnitude with sign on top
  function automatic logic [64:0] split_signed(logic [31:0] x);
    logic [63:0] mag;
    mag = x[31] ? {32'd0, (~x) + 32'd1} : {32'd0, x};
    if (x == MinInt) mag = 64'h8000_0000;
    return {x[31], mag};
  endfunction

  function automatic out_t reduce_fraction(in_t it);
    logic [64:0] an, ad, bn, bd;
    logic [63:0] p, q, num, den, g, x, y, t;
    logic        p_neg, q_neg, num_neg, neg;
    out_t        r;
    an = split_signed(it.a_num);
    ad = split_signed(it.a_den);
    bn = split_signed(it.b_num);
    bd = split_signed(it.b_den);
    r = '0;
    if (ad[63:0] == 0 || bd[63:0] == 0 || (it.action == ActDiv && bn[63:0] == 0)) begin
      r.status = StZeroDen;
      return r;
    end
    if (it.action == ActMul) begin
      num = an[63:0] * bn[63:0];
      num_neg = an[64] ^ bn[64];
      den = ad[63:0] * bd[63:0];
    end else if (it.action == ActDiv) begin
      num = an[63:0] * bd[63:0];
      num_neg = an[64] ^ bd[64];
      den = ad[63:0] * bn[63:0];
    end else begin
      p = an[63:0] * bd[63:0];
      p_neg = (p != 0) && (an[64] ^ bd[64]);
      q = bn[63:0] * ad[63:0];
      q_neg = (q != 0) && (bn[64] ^ ad[64]);
      if (p_neg == q_neg) begin
        num = p + q;
        num_neg = p_neg;
      end else if (p >= q) begin
        num = p - q;
        num_neg = p_neg;
      end else begin
        num = q - p;
        num_neg = q_neg;
      end
      den = ad[63:0] * bd[63:0];
    end
    // denominator sign follows the factors that built it
    neg = num_neg ^ ((it.action == ActDiv) ? (ad[64] ^ bn[64]) : (ad[64] ^ bd[64]));
    if (num == 0) begin
      r.res_den = 31'd1;
      r.status = StOk;
      return r;
    end
    x = num;
    y = den;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    g = x;
    num = num / g;
    den = den / g;
    if (den > 64'h7fff_ffff || num > (neg ? 64'h8000_0000 : 64'h7fff_ffff)) begin
      r.status = StOvf;
      return r;
    end
    r.res_num = neg ? (~num[31:0]) + 32'd1 : num[31:0];
    r.res_den = den[30:0];
    r.status = StOk;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    mismatches++;
  endtask

  // one beat on the input side, with random idling before it
  task automatic send_item(in_t it);
    while (!no_idle && $urandom_range(99) < 30) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(reduce_fraction(it));
  endtask

  task automatic send_frac(logic [1:0] act, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    in_t it;
    it.action = act;
    it.a_num = an;
    it.a_den = ad;
    it.b_num = bn;
    it.b_den = bd;
    send_item(it);
  endtask

  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: v = MinInt;
          1: v = MaxInt;
          2: v = 32'hffff_ffff;
          3: v = 32'd1;
          default: v = 32'd0;
        endcase
      end
      1, 2, 3, 4: v = $urandom_range(200) - 100;
      5, 6: v = {{16{1'b0}}, 16'($urandom)} - 32'd32768;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_frac(2'($urandom), rand_operand(), rand_operand(), rand_operand(),
                rand_operand());
    end
  endtask

  task automatic test_extremes();
    send_frac(ActAdd, MaxInt, 32'd1, MaxInt, 32'd1);
    send_frac(ActAdd, MinInt, 32'd1, MaxInt, 32'd1);
    send_frac(ActMul, MinInt, 32'd1, 32'd1, 32'd1);
    send_frac(ActMul, MinInt, 32'd1, 32'hffff_ffff, 32'd1);
    send_frac(ActDiv, MaxInt, MinInt, MinInt, MaxInt);
    send_frac(ActMul, MinInt, MinInt, MaxInt, MaxInt);
    send_frac(ActDiv, 32'd3, 32'hffff_fffa, 32'hffff_fff8, 32'd4);
    send_frac(ActSpare, 32'd1, 32'd3, 32'd1, 32'd6);
    send_frac(ActAdd, 32'd6, 32'd4, 32'hffff_fffd, 32'hffff_fffe);
  endtask

  task automatic test_special_cases();
    send_frac(ActAdd, 32'd1, 32'd0, 32'd1, 32'd1);
    send_frac(ActMul, 32'd1, 32'd1, 32'd1, 32'd0);
    send_frac(ActDiv, 32'd5, 32'd7, 32'd0, 32'd3);
    send_frac(ActDiv, 32'd0, 32'd7, 32'd0, 32'd0);
    send_frac(ActAdd, 32'd1, 32'd2, 32'hffff_ffff, 32'd2);
    send_frac(ActMul, 32'd0, MinInt, MaxInt, 32'd9);
    send_frac(ActAdd, MaxInt, 32'd1, 32'd1, 32'd1);
    send_frac(ActDiv, 32'd1, MaxInt, 32'd2, 32'd1);
    send_frac(ActMul, 32'h0001_0000, 32'd1, 32'h0000_8000, 32'd1);
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    hold_cycles = 3000;
    send_random(20);
  endtask

  task automatic test_random();
    send_random(300);
    no_idle = 1'b1;
    send_random(200);
    no_idle = 1'b0;
    send_random(480);
  endtask

  // receiver side
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 30);
      end
    end
  end

  // result checker
  initial begin
    out_t want;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("FAIL");
        $finish;
      end
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat", out_data.res_num, 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.res_num !== want.res_num)
            report_mismatch("res_num", out_data.res_num, want.res_num);
          if (out_data.res_den !== want.res_den)
            report_mismatch("res_den", {1'b0, out_data.res_den}, {1'b0, want.res_den});
          if (out_data.status !== want.status)
            report_mismatch("status", {30'd0, out_data.status}, {30'd0, want.status});
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_special_cases();
    test_backpressure();
    test_random();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rau_pkg.sv
rtl/rau_div.sv
rtl/rational_arith_unit_top.sv
rtl/rau_checker.sv
bench/testbench.sv
